>>> src/bfrs_pkg.sv
package bfrs_pkg;

   // Default sizes of the delay line.
   localparam int DEF_MAX_WINDOW   = 256;
   localparam int DEF_MAX_CHANNELS = 4;

   // Fixed field widths of the streams.
   localparam int SAMPLE_W     = 8;
   localparam int SUM_W        = 16;
   localparam int CHANNEL_W    = 2;
   // Wide enough for a channel index at the largest supported channel count.
   localparam int CHAN_FIELD_W = 4;

   // Control and status register port.
   localparam int CSR_INDEX_W     = 2;
   localparam int WINDOW_SIZE_W   = 9;
   localparam int CHANNEL_COUNT_W = 3;
   localparam int CSR_DATA_W      = 9;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

   // Queue between the front and back halves.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // One classified sample on its way from the front half to the back half.
   typedef struct packed {
      logic [SAMPLE_W-1:0]     sample;
      logic [SAMPLE_W-1:0]     old_sample;
      logic [CHAN_FIELD_W-1:0] channel;
      logic                    clear;
      logic                    zero_win;
      logic                    sub;
      logic                    emit;
   } bfrs_item_type;

endpackage

>>> src/bfrs_stream_ifs.sv
interface bfrs_req_if import bfrs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                row_start;

   modport source (output valid, output sample, output row_start, input ready);
   modport sink   (input valid, input sample, input row_start, output ready);
endinterface

interface bfrs_rsp_if import bfrs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SUM_W-1:0]     window_sum;
   logic [CHANNEL_W-1:0] channel;

   modport source (output valid, output window_sum, output channel, input ready);
   modport sink   (input valid, input window_sum, input channel, output ready);
endinterface

>>> src/bfrs_queue.sv
module bfrs_queue import bfrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bfrs_item_type       push_item,
   input  logic                pop,
   output logic                head_valid,
   output bfrs_item_type       head_item,
   output logic [QCOUNT_W-1:0] count
);

   bfrs_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(32'(wr_ptr_ff) + 1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(32'(rd_ptr_ff) + 1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCOUNT_W'(32'(count_ff) + 1);
      end else if (pop && !push) begin
         count_in = QCOUNT_W'(32'(count_ff) - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   // The front half only takes a beat when a slot is reserved for it.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (32'(count_ff) < QUEUE_DEPTH) || pop)
      else $error("queue overflow");

endmodule

>>> src/bfrs_front.sv
module bfrs_front import bfrs_pkg::*; #(
   parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   bfrs_req_if.sink               req_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [QCOUNT_W-1:0]    queue_count,
   output logic                   push,
   output bfrs_item_type          push_item
);

   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
   localparam int LINE_DEPTH = MAX_CHANNELS * MAX_WINDOW;
   localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [WINDOW_SIZE_W-1:0]   window_size_ff, window_size_in;
   logic [CHANNEL_COUNT_W-1:0] channel_count_ff, channel_count_in;
   logic [CH_W-1:0]            chan_pos_ff, chan_pos_in;
   logic [CNT_W-1:0]           pixels_ff, pixels_in;
   logic [SLOT_W-1:0]          wptr_ff, wptr_in;
   logic                       s1_valid_ff, s1_valid_in;
   bfrs_item_type              s1_item_ff;
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic [SAMPLE_W-1:0]        delay_line [LINE_DEPTH];

   logic                accept;
   logic [31:0]         win_wide;
   logic [31:0]         cc_wide;
   logic [CH_W-1:0]     pos_cur;
   logic [CH_W-1:0]     chan;
   logic [CNT_W-1:0]    cnt_cur;
   logic [SLOT_W-1:0]   slot_cur;
   logic [31:0]         old_wide;
   logic [31:0]         chan_next_wide;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   bfrs_item_type       item;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (32'(queue_count) + 32'(s1_valid_ff)) < QUEUE_DEPTH;

   always_comb begin
      // Out-of-range register values act as the nearest legal value.
      win_wide = (32'(window_size_ff) > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW)
                                                         : 32'(window_size_ff);
      if (channel_count_ff == '0) begin
         cc_wide = 32'd1;
      end else if (32'(channel_count_ff) > 32'(MAX_CHANNELS)) begin
         cc_wide = 32'(MAX_CHANNELS);
      end else begin
         cc_wide = 32'(channel_count_ff);
      end

      // A row start behaves as if the row progress had been cleared first.
      pos_cur  = req_chan.row_start ? '0 : chan_pos_ff;
      cnt_cur  = req_chan.row_start ? '0 : pixels_ff;
      slot_cur = req_chan.row_start ? '0 : wptr_ff;
      chan     = (32'(pos_cur) >= cc_wide) ? '0 : pos_cur;

      old_wide = (32'(slot_cur) >= win_wide) ? 32'(slot_cur) - win_wide
                                             : 32'(slot_cur) + 32'(MAX_WINDOW) - win_wide;
      wr_addr  = ADDR_W'(32'(chan) * 32'(MAX_WINDOW) + 32'(slot_cur));
      rd_addr  = ADDR_W'(32'(chan) * 32'(MAX_WINDOW) + old_wide);

      item            = '0;
      item.sample     = req_chan.sample;
      item.channel    = CHAN_FIELD_W'(chan);
      item.clear      = req_chan.row_start;
      item.zero_win   = (win_wide == 32'd0);
      item.sub        = (32'(cnt_cur) >= win_wide);
      item.emit       = (win_wide == 32'd0) || (32'(cnt_cur) + 32'd1 >= win_wide);

      chan_next_wide  = 32'(chan) + 32'd1;

      window_size_in   = window_size_ff;
      channel_count_in = channel_count_ff;
      chan_pos_in      = chan_pos_ff;
      pixels_in        = pixels_ff;
      wptr_in          = wptr_ff;

      if (csr_we) begin
         case (csr_index)
            REG_WINDOW_SIZE:   window_size_in   = csr_wdata[WINDOW_SIZE_W-1:0];
            REG_CHANNEL_COUNT: channel_count_in = csr_wdata[CHANNEL_COUNT_W-1:0];
            default:           ;
         endcase
         // Any register write starts a fresh row.
         chan_pos_in = '0;
         pixels_in   = '0;
         wptr_in     = '0;
      end else if (accept) begin
         if (chan_next_wide >= cc_wide) begin
            chan_pos_in = '0;
            pixels_in   = (32'(cnt_cur) < 32'(MAX_WINDOW + 1))
                          ? CNT_W'(32'(cnt_cur) + 32'd1) : cnt_cur;
            wptr_in     = (32'(slot_cur) + 32'd1 == 32'(MAX_WINDOW))
                          ? '0 : SLOT_W'(32'(slot_cur) + 32'd1);
         end else begin
            chan_pos_in = CH_W'(chan_next_wide);
            pixels_in   = cnt_cur;
            wptr_in     = slot_cur;
         end
      end

      s1_valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= WINDOW_SIZE_W'(1);
         channel_count_ff <= CHANNEL_COUNT_W'(1);
         chan_pos_ff      <= '0;
         pixels_ff        <= '0;
         wptr_ff          <= '0;
         s1_valid_ff      <= 1'b0;
      end else begin
         window_size_ff   <= window_size_in;
         channel_count_ff <= channel_count_in;
         chan_pos_ff      <= chan_pos_in;
         pixels_ff        <= pixels_in;
         wptr_ff          <= wptr_in;
         s1_valid_ff      <= s1_valid_in;
      end
   end

   // The leaving sample is read before the new one lands, so a full-depth
   // window sees the old contents of the slot it overwrites.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff          <= delay_line[rd_addr];
         delay_line[wr_addr] <= req_chan.sample;
         s1_item_ff          <= item;
      end
   end

   always_comb begin
      push_item            = s1_item_ff;
      push_item.old_sample = rd_data_ff;
   end

   assign push = s1_valid_ff;

   a_csr_clears_row: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (chan_pos_ff == '0) && (pixels_ff == '0) && (wptr_ff == '0))
      else $error("register write did not clear the row progress");

endmodule

>>> src/bfrs_back.sv
module bfrs_back import bfrs_pkg::*; #(
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear_sums,
   input  logic          head_valid,
   input  bfrs_item_type head_item,
   output logic          pop,
   bfrs_rsp_if.source    rsp_chan
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [SUM_W-1:0]     sums_ff [MAX_CHANNELS];
   logic [SUM_W-1:0]     sums_in [MAX_CHANNELS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]     rsp_sum_ff;
   logic [CHANNEL_W-1:0] rsp_chan_ff;

   logic [CH_W-1:0]  idx;
   logic [SUM_W-1:0] base_sum;
   logic [SUM_W-1:0] sub_val;
   logic [SUM_W-1:0] new_sum;

   always_comb begin
      idx      = head_item.channel[CH_W-1:0];
      base_sum = head_item.clear ? '0 : sums_ff[idx];
      sub_val  = head_item.sub ? SUM_W'(head_item.old_sample) : '0;
      new_sum  = base_sum - sub_val + SUM_W'(head_item.sample);

      // A beat without a result never waits on the output register.
      pop = head_valid && (!head_item.emit || !rsp_valid_ff || rsp_chan.ready);

      sums_in = sums_ff;
      if (clear_sums) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            sums_in[i] = '0;
         end
      end else if (pop) begin
         if (head_item.clear) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
               sums_in[i] = '0;
            end
         end
         if (!head_item.zero_win) begin
            sums_in[idx] = new_sum;
         end
      end

      if (pop && head_item.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            sums_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         sums_ff      <= sums_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_item.emit) begin
         rsp_sum_ff  <= head_item.zero_win ? '0 : new_sum;
         rsp_chan_ff <= head_item.channel[CHANNEL_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.window_sum = rsp_sum_ff;
   assign rsp_chan.channel    = rsp_chan_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.emit) |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("pending result overwritten");

   a_zero_window_sum: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.zero_win) |=> (rsp_valid_ff && (rsp_sum_ff == '0)))
      else $error("zero window produced a nonzero sum");

endmodule

>>> src/box_filter_row_sum.sv
// Channel   Direction  Beat contents
// req_chan  in         sample[7:0], row_start
// rsp_chan  out        window_sum[15:0], channel[1:0]
// csr_*     in         csr_we, csr_index[1:0], csr_wdata[8:0]
//
// One beat is accepted per clock while the queue has room; each result is registered.
// The delay line is a single memory written and read once per beat, which
// sets the one-beat-per-clock rate; a four-entry queue separates it from the
// running-sum unit, so beats keep flowing while a result is stalled until the
// queue and the stage ahead of it hold four beats between them.
// Reset is synchronous and clears the control state and sums at once; the
// delay line is not cleared and needs no clearing pass.
module box_filter_row_sum import bfrs_pkg::*; #(
   parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   bfrs_req_if.sink               req_chan,
   bfrs_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                push;
   bfrs_item_type       push_item;
   logic                pop;
   logic                head_valid;
   bfrs_item_type       head_item;
   logic [QCOUNT_W-1:0] queue_count;

   bfrs_front #(
      .MAX_WINDOW   (MAX_WINDOW),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_count (queue_count),
      .push        (push),
      .push_item   (push_item)
   );

   bfrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (queue_count)
   );

   bfrs_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_sums (csr_we),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
